>>> rtl/core/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the button press classifier
// Event and LED codes, register indexes, reset values and default widths.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned CFG_W          = 16;
  localparam int unsigned CFG_ADDR_W     = 2;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } press_event_t;

  typedef enum logic [1:0] {
    LED_NONE  = 2'd0,
    LED_GREEN = 2'd1,
    LED_BLINK = 2'd2,
    LED_OFF   = 2'd3
  } led_action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_DOUBLE_GAP = 2'd2,
    REG_LED_HOLD   = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd300;
  localparam logic [CFG_W-1:0] LED_HOLD_RST   = 16'd60000;

endpackage

`default_nettype wire

>>> rtl/core/button_press_classifier.sv
// The result of an accepted tick is captured in the output register when the tick is accepted.
// Throughput: one tick per cycle while m_tready stays high; the classifier
// state and the single output register update in the cycle a tick is accepted.
// Reset (rst, synchronous): timers idle, no press pending, debounce window
// open, registers at their defaults (50, 1000, 300, 60000).
// ----------------------------------------------------------------------------
// button_press_classifier
// Sorts debounced button activity into single, double and long presses and
// derives an LED action for each millisecond tick.
// ----------------------------------------------------------------------------
`default_nettype none

module button_press_classifier
  import bpc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [7:0]            s_tdata,   // [0] button_level, [7:1] zero
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [7:0]                 m_tdata    // [1:0] press_event, [3:2] led_action
);

  localparam int unsigned CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration registers
  logic [CFG_W-1:0] debounce_ticks;
  logic [CFG_W-1:0] long_press_ticks;
  logic [CFG_W-1:0] double_gap_ticks;
  logic [CFG_W-1:0] led_hold_ticks;

  // Classifier state
  logic                  last_level;
  logic [COUNT_BITS-1:0] since_edge;
  logic [COUNT_BITS-1:0] press_length;
  logic                  single_waiting;
  logic [COUNT_BITS-1:0] gap_count;
  logic [COUNT_BITS-1:0] led_count;
  logic                  led_armed;

  logic                  last_level_next;
  logic [COUNT_BITS-1:0] since_edge_next;
  logic [COUNT_BITS-1:0] press_length_next;
  logic                  single_waiting_next;
  logic [COUNT_BITS-1:0] gap_count_next;
  logic [COUNT_BITS-1:0] led_count_next;
  logic                  led_armed_next;

  // Output register
  logic         out_valid;
  press_event_t out_event;
  led_action_t  out_led;
  press_event_t ev_next;
  led_action_t  led_next;

  logic level;
  logic s_fire;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic ge_cfg(input logic [COUNT_BITS-1:0] cnt,
                                  input logic [CFG_W-1:0] lim);
    logic [CMP_W-1:0] a;
    logic [CMP_W-1:0] b;
    a = CMP_W'(cnt);
    b = CMP_W'(lim);
    return a >= b;
  endfunction

  assign level    = s_tdata[0];
  assign s_tready = !out_valid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_led, out_event};

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_RST;
      long_press_ticks <= LONG_PRESS_RST;
      double_gap_ticks <= DOUBLE_GAP_RST;
      led_hold_ticks   <= LED_HOLD_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        REG_LONG_PRESS: long_press_ticks <= cfg_data;
        REG_DOUBLE_GAP: double_gap_ticks <= cfg_data;
        REG_LED_HOLD:   led_hold_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    since_edge_next     = sat_inc(since_edge);
    press_length_next   = sat_inc(press_length);
    gap_count_next      = single_waiting ? sat_inc(gap_count) : gap_count;
    led_count_next      = led_armed ? sat_inc(led_count) : led_count;
    last_level_next     = level;
    single_waiting_next = single_waiting;
    led_armed_next      = led_armed;
    ev_next             = EV_NONE;
    led_next            = LED_NONE;

    // A rejected edge still moves last_level to the new raw sample.
    if (level != last_level && ge_cfg(since_edge_next, debounce_ticks)) begin
      since_edge_next = '0;
      if (level) begin
        press_length_next = '0;
      end else if (ge_cfg(press_length_next, long_press_ticks)) begin
        single_waiting_next = 1'b0;
        ev_next             = EV_LONG;
      end else if (single_waiting) begin
        single_waiting_next = 1'b0;
        ev_next             = EV_DOUBLE;
      end else begin
        single_waiting_next = 1'b1;
        gap_count_next      = '0;
      end
    end

    if (ev_next == EV_NONE && single_waiting_next &&
        ge_cfg(gap_count_next, double_gap_ticks)) begin
      single_waiting_next = 1'b0;
      ev_next             = EV_SINGLE;
    end

    case (ev_next)
      EV_SINGLE: begin
        led_next       = LED_GREEN;
        led_armed_next = 1'b1;
        led_count_next = '0;
      end
      EV_DOUBLE: begin
        led_next       = LED_BLINK;
        led_armed_next = 1'b0;
      end
      EV_LONG: begin
        led_next       = LED_OFF;
        led_armed_next = 1'b0;
      end
      default: begin
        if (led_armed && ge_cfg(led_count_next, led_hold_ticks)) begin
          led_next       = LED_OFF;
          led_armed_next = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      since_edge     <= CNT_MAX;
      press_length   <= '0;
      single_waiting <= 1'b0;
      gap_count      <= '0;
      led_count      <= '0;
      led_armed      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (s_fire) begin
        last_level     <= last_level_next;
        since_edge     <= since_edge_next;
        press_length   <= press_length_next;
        single_waiting <= single_waiting_next;
        gap_count      <= gap_count_next;
        led_count      <= led_count_next;
        led_armed      <= led_armed_next;
        out_valid      <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      out_event <= ev_next;
      out_led   <= led_next;
    end
  end

  // The auto-off timer is armed only by a single press reported in the same item.
  a_arm_on_single: assert property (@(posedge clk) disable iff (rst)
    $rose(led_armed) |-> (out_valid && out_event == EV_SINGLE))
    else $error("LED timer armed without a single press");

  // A double press needs a short release already waiting.
  a_double_needs_wait: assert property (@(posedge clk) disable iff (rst)
    (s_fire && !single_waiting) |=> (out_event != EV_DOUBLE))
    else $error("double press reported with no press waiting");

  // Every press event carries its fixed LED action.
  a_event_led_map: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_event == EV_NONE   && (out_led == LED_NONE || out_led == LED_OFF)) ||
                   (out_event == EV_SINGLE && out_led == LED_GREEN) ||
                   (out_event == EV_DOUBLE && out_led == LED_BLINK) ||
                   (out_event == EV_LONG   && out_led == LED_OFF)))
    else $error("LED action does not match press event");

  // Any LED off, timer-driven or from a long press, leaves the timer disarmed.
  a_off_disarms: assert property (@(posedge clk) disable iff (rst)
    (s_fire && led_next == LED_OFF) |=> !led_armed)
    else $error("LED timer still armed after turn off");

endmodule

`default_nettype wire
